@@ design/st_pkg.sv @@
// ----------------------------------------------------------------------------
// st_pkg
// Shared types, token kind codes and character class helpers of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package st_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_STRING,
        MODE_ZERO,
        MODE_NUM,
        MODE_WORD
    } mode_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] stop;
        logic        last;
    } tok_t;

    typedef struct packed {
        logic hit;
        tok_t tok;
    } flush_t;

    localparam int KEYWORD_CHARS = 8;

    localparam logic [5:0] K_SHL_EQ   = 6'd15;
    localparam logic [5:0] K_SHL      = 6'd16;
    localparam logic [5:0] K_SHR_EQ   = 6'd19;
    localparam logic [5:0] K_SHR      = 6'd20;
    localparam logic [5:0] K_STRING   = 6'd47;
    localparam logic [5:0] K_LINEFEED = 6'd48;
    localparam logic [5:0] K_NUMBER   = 6'd49;
    localparam logic [5:0] K_TRUE     = 6'd50;
    localparam logic [5:0] K_IDENT    = 6'd59;
    localparam logic [5:0] K_INVALID  = 6'd60;

    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_B     = 8'h62;

    // keywords packed first character in the low byte
    localparam logic [63:0] KW_TEXT [9] = '{
        64'h0000_0000_6575_7274,   // true
        64'h0000_0065_736c_6166,   // false
        64'h0000_0000_6c6c_756e,   // null
        64'h0000_6863_6e61_7262,   // branch
        64'h0000_0000_706f_6f6c,   // loop
        64'h6e6f_6974_636e_7566,   // function
        64'h0000_6e72_7574_6572,   // return
        64'h0000_006b_6165_7262,   // break
        64'h6575_6e69_746e_6f63    // continue
    };

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic id_first(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
            || c == 8'h5f || c == 8'h24;
    endfunction

    function automatic logic id_next(logic [7:0] c);
        return id_first(c) || is_digit(c);
    endfunction

    // {valid, kind}
    function automatic logic [6:0] punct_kind(logic [7:0] c);
        logic [6:0] r;
        unique case (c)
            8'h7b:   r = {1'b1, 6'd0};
            8'h7d:   r = {1'b1, 6'd1};
            8'h28:   r = {1'b1, 6'd2};
            8'h29:   r = {1'b1, 6'd3};
            8'h5b:   r = {1'b1, 6'd4};
            8'h5d:   r = {1'b1, 6'd5};
            8'h2c:   r = {1'b1, 6'd6};
            8'h3a:   r = {1'b1, 6'd7};
            8'h3b:   r = {1'b1, 6'd8};
            8'h2e:   r = {1'b1, 6'd9};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] single_op(logic [7:0] c);
        logic [6:0] r;
        unique case (c)
            8'h3d:   r = {1'b1, 6'd11};
            8'h21:   r = {1'b1, 6'd13};
            8'h3c:   r = {1'b1, 6'd17};
            8'h3e:   r = {1'b1, 6'd21};
            8'h2b:   r = {1'b1, 6'd24};
            8'h2d:   r = {1'b1, 6'd27};
            8'h2a:   r = {1'b1, 6'd30};
            8'h2f:   r = {1'b1, 6'd34};
            8'h25:   r = {1'b1, 6'd36};
            8'h7c:   r = {1'b1, 6'd39};
            8'h26:   r = {1'b1, 6'd42};
            8'h5e:   r = {1'b1, 6'd44};
            8'h7e:   r = {1'b1, 6'd46};
            default: r = 7'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] pair_op(logic [7:0] f, logic [7:0] c);
        logic [6:0] r;
        r = 7'd0;
        if (c == CH_EQ) begin
            unique case (f)
                8'h3d:   r = {1'b1, 6'd10};
                8'h21:   r = {1'b1, 6'd12};
                8'h3c:   r = {1'b1, 6'd14};
                8'h3e:   r = {1'b1, 6'd18};
                8'h2b:   r = {1'b1, 6'd22};
                8'h2d:   r = {1'b1, 6'd25};
                8'h2a:   r = {1'b1, 6'd28};
                8'h2f:   r = {1'b1, 6'd31};
                8'h25:   r = {1'b1, 6'd35};
                8'h7c:   r = {1'b1, 6'd38};
                8'h26:   r = {1'b1, 6'd41};
                8'h5e:   r = {1'b1, 6'd43};
                8'h7e:   r = {1'b1, 6'd45};
                default: r = 7'd0;
            endcase
        end else if (f == 8'h2b && c == 8'h2b) begin
            r = {1'b1, 6'd23};
        end else if (f == 8'h2d && c == 8'h2d) begin
            r = {1'b1, 6'd26};
        end else if (f == 8'h2a && c == 8'h2f) begin
            r = {1'b1, 6'd29};
        end else if (f == 8'h2f && c == 8'h2a) begin
            r = {1'b1, 6'd32};
        end else if (f == 8'h2f && c == 8'h2f) begin
            r = {1'b1, 6'd33};
        end else if (f == 8'h7c && c == 8'h7c) begin
            r = {1'b1, 6'd37};
        end else if (f == 8'h26 && c == 8'h26) begin
            r = {1'b1, 6'd40};
        end
        return r;
    endfunction

    function automatic logic [5:0] word_kind(logic [63:0] w, logic too_long);
        logic [5:0] k;
        k = K_IDENT;
        if (!too_long) begin
            for (int i = 8; i >= 0; i--) begin
                if (KW_TEXT[i] == w) begin
                    k = K_TRUE + 6'(i);
                end
            end
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ design/st_queue.sv @@
// ----------------------------------------------------------------------------
// st_queue
// Four-entry token queue: takes up to two tokens per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module st_queue (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [1:0]   wr_n,
    input  wire st_pkg::tok_t wr_tok0,
    input  wire st_pkg::tok_t wr_tok1,
    output logic              room,
    output logic              rd_valid,
    input  wire logic         rd_ready,
    output st_pkg::tok_t      rd_tok
);
    import st_pkg::*;

    tok_t       mem [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       rd_go;

    assign rd_valid = count_reg != 3'd0;
    assign rd_go    = rd_valid && rd_ready;
    assign room     = count_reg <= 3'd2;
    assign rd_tok   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg + wr_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, rd_go};
        count_next  = count_reg + {1'b0, wr_n} - {2'b0, rd_go};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_n != 2'd0) begin
            mem[wr_ptr_reg] <= wr_tok0;
        end
        if (wr_n == 2'd2) begin
            mem[wr_ptr_reg + 2'd1] <= wr_tok1;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("token queue overfilled");
    a_write_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_n != 2'd0 |-> room)
        else $error("token write without room");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_n == 2'd0 && !rd_go) |=> $stable(count_reg))
        else $error("queue count moved while idle");
`endif

endmodule

`default_nettype wire

@@ design/source_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexical tokenizer, one source byte per transfer.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the token queue has room; each byte is
// registered, then combinational lookahead logic updates the scan state and
// writes zero, one or two tokens into a four-entry queue in front of the
// result port. Sustained rate is one byte per cycle as long as bytes average
// at most one token each and m_tready stays high; the queue soaks up the extra
// token of a byte that yields two. Tokens that wait for lookahead (operators,
// numbers, identifiers) leave with the following byte or at the line end;
// strings stay open across lines until their closing quote.
`default_nettype none

module source_tokenizer #(
    parameter int POS_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // char_code[7:0], char_position[39:8]
    input  wire logic        s_tlast,   // line_end
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,   // token_kind[5:0], token_start[37:6],
                                        // token_end[69:38], zero pad
    output logic             m_tlast    // last_token
);
    import st_pkg::*;

    typedef logic [POS_BITS-1:0] pos_t;

    // registered input byte
    logic       in_valid_reg;
    logic [7:0] in_code_reg;
    pos_t       in_pos_reg;
    logic       in_le_reg;

    // scan state
    mode_t       mode_reg, mode_next;
    logic [7:0]  op1_reg, op1_next;
    logic        op2_reg, op2_next;
    logic [7:0]  quote_reg, quote_next;
    pos_t        start_reg, start_next;
    logic [31:0] run_reg, run_next;
    logic [63:0] word_reg, word_next;
    logic        long_reg, long_next;

    logic       proc_go;
    logic       q_room;
    logic [1:0] tok_n;
    tok_t       tok0, tok1;
    tok_t       rd_tok;

    function automatic logic [31:0] out_pos(pos_t p);
        return 32'(p);
    endfunction

    function automatic pos_t add_len(pos_t s, logic [31:0] len);
        return s + POS_BITS'(len);
    endfunction

    function automatic flush_t do_flush(mode_t m, logic [7:0] f, logic two, pos_t s,
                                        logic [31:0] run, logic [63:0] w, logic lg);
        flush_t r;
        r.hit       = 1'b1;
        r.tok.last  = 1'b0;
        r.tok.start = out_pos(s);
        unique case (m)
            MODE_OP: begin
                if (two) begin
                    r.tok.kind = (f == CH_LT) ? K_SHL : K_SHR;
                    r.tok.stop = out_pos(add_len(s, 32'd2));
                end else begin
                    r.tok.kind = 6'(single_op(f));
                    r.tok.stop = out_pos(add_len(s, 32'd1));
                end
            end
            MODE_ZERO, MODE_NUM: begin
                r.tok.kind = K_NUMBER;
                r.tok.stop = out_pos(add_len(s, run));
            end
            MODE_WORD: begin
                r.tok.kind = word_kind(w, lg);
                r.tok.stop = out_pos(add_len(s, run));
            end
            default: begin
                r.hit      = 1'b0;
                r.tok.kind = '0;
                r.tok.stop = '0;
            end
        endcase
        return r;
    endfunction

    assign proc_go  = in_valid_reg && q_room;
    assign s_tready = !in_valid_reg || proc_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_code_reg <= s_tdata[7:0];
            in_pos_reg  <= POS_BITS'(s_tdata[39:8]);
            in_le_reg   <= s_tlast;
        end
    end

    // scan step: mode action, then start of a new token, then line end flush
    always_comb begin
        logic       used;
        logic [6:0] pk;
        logic [6:0] pr;
        logic [6:0] so;
        flush_t     fl;
        tok_t       t;
        logic [7:0] c;
        pos_t       pos1;

        c          = in_code_reg;
        pos1       = in_pos_reg + POS_BITS'(1);
        mode_next  = mode_reg;
        op1_next   = op1_reg;
        op2_next   = op2_reg;
        quote_next = quote_reg;
        start_next = start_reg;
        run_next   = run_reg;
        word_next  = word_reg;
        long_next  = long_reg;
        used       = 1'b0;
        tok_n      = 2'd0;
        tok0       = '0;
        tok1       = '0;
        t          = '0;
        pr         = pair_op(op1_reg, c);
        pk         = punct_kind(c);
        so         = single_op(c);
        fl         = do_flush(mode_reg, op1_reg, op2_reg, start_reg, run_reg,
                              word_reg, long_reg);

        unique case (mode_reg)
            MODE_STRING: begin
                used = 1'b1;
                if (c == quote_reg) begin
                    t.kind  = K_STRING;
                    t.start = out_pos(start_reg);
                    t.stop  = out_pos(add_len(start_reg, run_reg));
                    tok0    = t;
                    tok_n   = 2'd1;
                    mode_next  = MODE_IDLE;
                    quote_next = '0;
                end else begin
                    run_next = run_reg + 32'd1;
                end
            end
            MODE_OP: begin
                if (op2_reg && c == CH_EQ) begin
                    t.kind  = (op1_reg == CH_LT) ? K_SHL_EQ : K_SHR_EQ;
                    t.start = out_pos(start_reg);
                    t.stop  = out_pos(add_len(start_reg, 32'd3));
                    tok0    = t;
                    tok_n   = 2'd1;
                    mode_next = MODE_IDLE;
                    op2_next  = 1'b0;
                    used      = 1'b1;
                end else if (!op2_reg && (op1_reg == CH_LT || op1_reg == CH_GT)
                             && c == op1_reg) begin
                    op2_next = 1'b1;
                    used     = 1'b1;
                end else if (!op2_reg && pr[6]) begin
                    t.kind  = pr[5:0];
                    t.start = out_pos(start_reg);
                    t.stop  = out_pos(add_len(start_reg, 32'd2));
                    tok0    = t;
                    tok_n   = 2'd1;
                    mode_next = MODE_IDLE;
                    used      = 1'b1;
                end else begin
                    tok0      = fl.tok;
                    tok_n     = 2'd1;
                    mode_next = MODE_IDLE;
                    op2_next  = 1'b0;
                end
            end
            MODE_ZERO: begin
                if (c == CH_X || c == CH_B || is_digit(c)) begin
                    run_next  = run_reg + 32'd1;
                    mode_next = MODE_NUM;
                    used      = 1'b1;
                end else begin
                    tok0      = fl.tok;
                    tok_n     = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                if (is_digit(c)) begin
                    run_next = run_reg + 32'd1;
                    used     = 1'b1;
                end else begin
                    tok0      = fl.tok;
                    tok_n     = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_WORD: begin
                if (id_next(c)) begin
                    if (run_reg < 32'(KEYWORD_CHARS) && !long_reg) begin
                        word_next[8*run_reg[2:0] +: 8] = c;
                    end else begin
                        long_next = 1'b1;
                    end
                    run_next = run_reg + 32'd1;
                    used     = 1'b1;
                end else begin
                    tok0      = fl.tok;
                    tok_n     = 2'd1;
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        if (!used) begin
            t.start   = out_pos(in_pos_reg);
            t.stop    = out_pos(pos1);
            t.kind    = '0;
            mode_next = MODE_IDLE;
            if (c == CH_SQ || c == CH_DQ) begin
                mode_next  = MODE_STRING;
                quote_next = c;
                start_next = pos1;
                run_next   = '0;
            end else if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
                t.kind = '0;
            end else if (c == CH_LF || pk[6]) begin
                t.kind = pk[6] ? pk[5:0] : K_LINEFEED;
                if (tok_n == 2'd0) begin
                    tok0 = t;
                end else begin
                    tok1 = t;
                end
                tok_n = tok_n + 2'd1;
            end else if (so[6]) begin
                mode_next  = MODE_OP;
                op1_next   = c;
                op2_next   = 1'b0;
                start_next = in_pos_reg;
            end else if (is_digit(c)) begin
                mode_next  = (c == CH_ZERO) ? MODE_ZERO : MODE_NUM;
                start_next = in_pos_reg;
                run_next   = 32'd1;
            end else if (id_first(c)) begin
                mode_next  = MODE_WORD;
                start_next = in_pos_reg;
                run_next   = 32'd1;
                word_next  = {56'd0, c};
                long_next  = 1'b0;
            end else begin
                t.kind = K_INVALID;
                if (tok_n == 2'd0) begin
                    tok0 = t;
                end else begin
                    tok1 = t;
                end
                tok_n = tok_n + 2'd1;
            end
        end

        if (in_le_reg) begin
            fl = do_flush(mode_next, op1_next, op2_next, start_next, run_next,
                          word_next, long_next);
            if (fl.hit) begin
                if (tok_n == 2'd0) begin
                    tok0 = fl.tok;
                end else begin
                    tok1 = fl.tok;
                end
                tok_n     = tok_n + 2'd1;
                mode_next = MODE_IDLE;
                op2_next  = 1'b0;
            end
        end

        tok0.last = (tok_n == 2'd1);
        tok1.last = 1'b1;
        if (!proc_go) begin
            tok_n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            op1_reg   <= '0;
            op2_reg   <= 1'b0;
            quote_reg <= '0;
            start_reg <= '0;
            run_reg   <= '0;
            word_reg  <= '0;
            long_reg  <= 1'b0;
        end else if (proc_go) begin
            mode_reg  <= mode_next;
            op1_reg   <= op1_next;
            op2_reg   <= op2_next;
            quote_reg <= quote_next;
            start_reg <= start_next;
            run_reg   <= run_next;
            word_reg  <= word_next;
            long_reg  <= long_next;
        end
    end

    st_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_n     (tok_n),
        .wr_tok0  (tok0),
        .wr_tok1  (tok1),
        .room     (q_room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_tok   (rd_tok)
    );

    assign m_tdata = {2'b00, rd_tok.stop, rd_tok.start, rd_tok.kind};
    assign m_tlast = rd_tok.last;

`ifndef NO_ASSERTIONS
    a_string_quote: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_STRING |-> (quote_reg == CH_SQ || quote_reg == CH_DQ))
        else $error("open string without quote");
    a_op_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_OP |-> single_op(op1_reg) != 7'd0)
        else $error("pending operator byte is not an operator");
    a_shift_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == MODE_OP && op2_reg) |-> (op1_reg == CH_LT || op1_reg == CH_GT))
        else $error("doubled operator is not a shift");
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

@@ tb/sv/source_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// source_tokenizer_tb
// Self-checking bench: random and directed source bytes against a predictor.
// ----------------------------------------------------------------------------
// Bytes are pushed through the input stream while a software tokenizer keeps
// its own scan state and queues the tokens each byte should cause. Every token
// transfer is compared field by field against the oldest queued token.
`default_nettype none

class token_scoreboard;
    typedef struct packed {
        logic [5:0]  kind;
        logic [31:0] start;
        logic [31:0] stop;
        logic        last;
    } token_s;

    token_s              pending_tokens[$];
    int                  mismatches;

    st_pkg::mode_t       mode;
    logic [15:0]         op_chars;
    logic [7:0]          quote;
    logic [31:0]         tok_start;
    logic [31:0]         run_len;
    logic [63:0]         word;
    logic                word_long;
    token_s              step_toks[$];

    function new();
        mode = st_pkg::MODE_IDLE;
        op_chars = '0;
        quote = '0;
        tok_start = '0;
        run_len = '0;
        word = '0;
        word_long = 1'b0;
        mismatches = 0;
    endfunction

    function void emit(logic [5:0] k, logic [31:0] s, logic [31:0] e);
        token_s t;
        if (step_toks.size() >= 2) return;
        t.kind = k;
        t.start = s;
        t.stop = e;
        t.last = 1'b0;
        step_toks.push_back(t);
    endfunction

    function logic [5:0] kw_match();
        logic [5:0] k;
        k = st_pkg::K_IDENT;
        if (!word_long) begin
            for (int i = 0; i < 9; i++) begin
                if (st_pkg::KW_TEXT[i] == word && k == st_pkg::K_IDENT) begin
                    k = st_pkg::K_TRUE + 6'(i);
                end
            end
        end
        return k;
    endfunction

    function logic [6:0] op_single(logic [7:0] c);
        case (c)
            "=": return {1'b1, 6'd11};
            "!": return {1'b1, 6'd13};
            "<": return {1'b1, 6'd17};
            ">": return {1'b1, 6'd21};
            "+": return {1'b1, 6'd24};
            "-": return {1'b1, 6'd27};
            "*": return {1'b1, 6'd30};
            "/": return {1'b1, 6'd34};
            "%": return {1'b1, 6'd36};
            "|": return {1'b1, 6'd39};
            "&": return {1'b1, 6'd42};
            "^": return {1'b1, 6'd44};
            "~": return {1'b1, 6'd46};
            default: return 7'd0;
        endcase
    endfunction

    function logic [6:0] op_pair(logic [7:0] f, logic [7:0] c);
        if (c == "=") begin
            case (f)
                "=": return {1'b1, 6'd10};
                "!": return {1'b1, 6'd12};
                "<": return {1'b1, 6'd14};
                ">": return {1'b1, 6'd18};
                "+": return {1'b1, 6'd22};
                "-": return {1'b1, 6'd25};
                "*": return {1'b1, 6'd28};
                "/": return {1'b1, 6'd31};
                "%": return {1'b1, 6'd35};
                "|": return {1'b1, 6'd38};
                "&": return {1'b1, 6'd41};
                "^": return {1'b1, 6'd43};
                "~": return {1'b1, 6'd45};
                default: return 7'd0;
            endcase
        end
        if (f == "+" && c == "+") return {1'b1, 6'd23};
        if (f == "-" && c == "-") return {1'b1, 6'd26};
        if (f == "*" && c == "/") return {1'b1, 6'd29};
        if (f == "/" && c == "*") return {1'b1, 6'd32};
        if (f == "/" && c == "/") return {1'b1, 6'd33};
        if (f == "|" && c == "|") return {1'b1, 6'd37};
        if (f == "&" && c == "&") return {1'b1, 6'd40};
        return 7'd0;
    endfunction

    function logic [6:0] punct(logic [7:0] c);
        case (c)
            "{": return {1'b1, 6'd0};
            "}": return {1'b1, 6'd1};
            "(": return {1'b1, 6'd2};
            ")": return {1'b1, 6'd3};
            "[": return {1'b1, 6'd4};
            "]": return {1'b1, 6'd5};
            ",": return {1'b1, 6'd6};
            ":": return {1'b1, 6'd7};
            ";": return {1'b1, 6'd8};
            ".": return {1'b1, 6'd9};
            default: return 7'd0;
        endcase
    endfunction

    function logic digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function logic ident_head(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == "$";
    endfunction

    function void flush();
        case (mode)
            st_pkg::MODE_OP: begin
                if (op_chars[15:8] != 0)
                    emit(op_chars[7:0] == st_pkg::CH_LT ? st_pkg::K_SHL : st_pkg::K_SHR,
                         tok_start, tok_start + 32'd2);
                else
                    emit(6'(op_single(op_chars[7:0])), tok_start, tok_start + 32'd1);
                op_chars = '0;
            end
            st_pkg::MODE_ZERO, st_pkg::MODE_NUM:
                emit(st_pkg::K_NUMBER, tok_start, tok_start + run_len);
            st_pkg::MODE_WORD:
                emit(kw_match(), tok_start, tok_start + run_len);
            default: return;
        endcase
        mode = st_pkg::MODE_IDLE;
    endfunction

    function void start_char(logic [7:0] c, logic [31:0] pos);
        logic [6:0] p;
        p = punct(c);
        mode = st_pkg::MODE_IDLE;
        if (c == st_pkg::CH_SQ || c == st_pkg::CH_DQ) begin
            mode = st_pkg::MODE_STRING;
            quote = c;
            tok_start = pos + 32'd1;
            run_len = '0;
        end else if (c == st_pkg::CH_SP || c == st_pkg::CH_TAB || c == st_pkg::CH_CR) begin
        end else if (c == st_pkg::CH_LF) begin
            emit(st_pkg::K_LINEFEED, pos, pos + 32'd1);
        end else if (p[6]) begin
            emit(p[5:0], pos, pos + 32'd1);
        end else if (op_single(c) != 0) begin
            mode = st_pkg::MODE_OP;
            op_chars = {8'h00, c};
            tok_start = pos;
        end else if (digit(c)) begin
            mode = c == st_pkg::CH_ZERO ? st_pkg::MODE_ZERO : st_pkg::MODE_NUM;
            tok_start = pos;
            run_len = 32'd1;
        end else if (ident_head(c)) begin
            mode = st_pkg::MODE_WORD;
            tok_start = pos;
            run_len = 32'd1;
            word = {56'd0, c};
            word_long = 1'b0;
        end else begin
            emit(st_pkg::K_INVALID, pos, pos + 32'd1);
        end
    endfunction

    // one accepted byte: advance scan state and queue its tokens
    function void note_char(logic [7:0] c, logic [31:0] pos, logic eol);
        logic used;
        logic [6:0] k;
        used = 1'b0;
        step_toks.delete();
        case (mode)
            st_pkg::MODE_STRING: begin
                if (c == quote) begin
                    emit(st_pkg::K_STRING, tok_start, tok_start + run_len);
                    mode = st_pkg::MODE_IDLE;
                    quote = '0;
                end else begin
                    run_len = run_len + 32'd1;
                end
                used = 1'b1;
            end
            st_pkg::MODE_OP: begin
                if (op_chars[15:8] != 0) begin
                    if (c == st_pkg::CH_EQ) begin
                        emit(op_chars[7:0] == st_pkg::CH_LT ? st_pkg::K_SHL_EQ
                             : st_pkg::K_SHR_EQ, tok_start, tok_start + 32'd3);
                        op_chars = '0;
                        mode = st_pkg::MODE_IDLE;
                        used = 1'b1;
                    end else begin
                        flush();
                    end
                end else if ((op_chars[7:0] == st_pkg::CH_LT || op_chars[7:0] == st_pkg::CH_GT)
                             && c == op_chars[7:0]) begin
                    op_chars[15:8] = c;
                    used = 1'b1;
                end else begin
                    k = op_pair(op_chars[7:0], c);
                    if (k[6]) begin
                        emit(k[5:0], tok_start, tok_start + 32'd2);
                        op_chars = '0;
                        mode = st_pkg::MODE_IDLE;
                        used = 1'b1;
                    end else begin
                        flush();
                    end
                end
            end
            st_pkg::MODE_ZERO: begin
                if (c == st_pkg::CH_X || c == st_pkg::CH_B || digit(c)) begin
                    run_len = run_len + 32'd1;
                    mode = st_pkg::MODE_NUM;
                    used = 1'b1;
                end else begin
                    flush();
                end
            end
            st_pkg::MODE_NUM: begin
                if (digit(c)) begin
                    run_len = run_len + 32'd1;
                    used = 1'b1;
                end else begin
                    flush();
                end
            end
            st_pkg::MODE_WORD: begin
                if (ident_head(c) || digit(c)) begin
                    if (run_len < st_pkg::KEYWORD_CHARS && !word_long)
                        word = word | ({56'd0, c} << (8 * run_len));
                    else
                        word_long = 1'b1;
                    run_len = run_len + 32'd1;
                    used = 1'b1;
                end else begin
                    flush();
                end
            end
            default: mode = st_pkg::MODE_IDLE;
        endcase
        if (!used) start_char(c, pos);
        if (eol) flush();
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
        foreach (step_toks[i]) pending_tokens.push_back(step_toks[i]);
    endfunction

    function void check_token(logic [71:0] data, logic last);
        token_s exp_t;
        token_s got;
        got.kind = data[5:0];
        got.start = data[37:6];
        got.stop = data[69:38];
        got.last = last;
        if (pending_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("token with none expected: kind %0d start %h end %h last %b",
                         got.kind, got.start, got.stop, got.last);
            return;
        end
        exp_t = pending_tokens.pop_front();
        if (got !== exp_t || data[71:70] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
                $display("token mismatch: exp kind %0d start %h end %h last %b, got %0d %h %h %b",
                         exp_t.kind, exp_t.start, exp_t.stop, exp_t.last,
                         got.kind, got.start, got.stop, got.last);
        end
    endfunction
endclass

module source_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    token_scoreboard tokens = new();
    int  src_idle_pct = 0;
    int  sink_idle_pct = 0;
    int  quiet_cycles = 0;
    logic [31:0] file_pos = 32'd0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    source_tokenizer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                tokens.note_char(s_tdata[7:0], s_tdata[39:8], s_tlast);
            if (m_tvalid && m_tready)
                tokens.check_token(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("source_tokenizer verification failed");
            $finish;
        end
    end

    // valid stays high after the transfer; the next call or drain() moves it
    task automatic send_char(logic [7:0] c, logic eol);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {file_pos, c};
        s_tlast <= eol;
        file_pos = file_pos + 32'd1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_text(string txt, logic eol);
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], eol && i == txt.len() - 1);
    endtask

    function automatic logic [7:0] pick_char();
        string alpha;
        alpha = "{}()[],:;.=!<>+-*/%|&^~\"' \t\r\n0123456789xbAZaz_$";
        case ($urandom_range(9))
            0: return 8'($urandom_range(255));
            1, 2: return "a" + 8'($urandom_range(25));
            3: return "0" + 8'($urandom_range(9));
            default: return alpha[$urandom_range(alpha.len() - 1)];
        endcase
    endfunction

    task automatic random_run(int count);
        string kw[9] = '{"true", "false", "null", "branch", "loop", "function",
                         "return", "break", "continue"};
        string ops[12] = '{"<<=", ">>=", "<<", ">>", "==", "!=", "++", "--", "*/",
                           "/*", "//", "&&"};
        int n;
        n = 0;
        while (n < count) begin
            case ($urandom_range(5))
                0: send_text(kw[$urandom_range(8)], 1'b0);
                1: send_text(ops[$urandom_range(11)], 1'b0);
                2: begin
                    send_char("0", 1'b0);
                    send_char($urandom_range(1) ? st_pkg::CH_X : st_pkg::CH_B, 1'b0);
                    send_char("7", $urandom_range(3) == 0);
                end
                3: begin
                    send_char(st_pkg::CH_DQ, 1'b0);
                    repeat ($urandom_range(4)) send_char(pick_char() & 8'h7f | 8'h40,
                                                         $urandom_range(5) == 0);
                    send_char(st_pkg::CH_DQ, 1'b0);
                end
                default: send_char(pick_char(), $urandom_range(6) == 0);
            endcase
            n += 4;
        end
        // send a single quote, a double quote and a space, each marked as a line end
        send_char(st_pkg::CH_SQ, 1'b1);
        send_char(st_pkg::CH_DQ, 1'b1);
        send_char(st_pkg::CH_SP, 1'b1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tokens.pending_tokens.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: punctuation, operator forms, number prefixes, keywords
        send_text("{}()[],:;.", 1'b0);
        send_text("<<=>>=<<a>>b<=>===!=!", 1'b0);
        send_text("+=++-=--*=*//=/*//%=%||", 1'b0);
        send_text("|=|&&&=&^=^~=~ /", 1'b1);
        send_text("0x12 0b9 007 123", 1'b1);
        send_text("true false null branch loop function return break continue", 1'b0);
        send_text(" functions continuex _$a9\t\r\n", 1'b0);
        send_char(8'h80, 1'b0);
        send_char(8'hff, 1'b0);
        send_char(8'h00, 1'b0);
        send_text("'a\"b", 1'b1);
        send_text("c'\"x\"", 1'b1);
        file_pos = 32'hffff_fffc;
        send_text("abcdefgh", 1'b1);
        drain();

        src_idle_pct = 30; sink_idle_pct = 83;
        random_run(500);
        drain();
        src_idle_pct = 83; sink_idle_pct = 30;
        file_pos = 32'h7fff_fff0 ^ $urandom;
        random_run(500);
        drain();
        src_idle_pct = 0; sink_idle_pct = 0;
        random_run(500);

        drain();
        repeat (20) @(posedge aclk);
        if (tokens.mismatches == 0 && tokens.pending_tokens.size() == 0)
            $display("source_tokenizer verification clean");
        else
            $display("source_tokenizer verification failed");
        $finish;
    end
endmodule

`default_nettype wire
